@@ src/lpsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants for the length-prefixed string deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int LEN_WIDTH   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int SEL_WIDTH   = 16;
  localparam int OUT_COUNT_WIDTH = 16;

  // Header accumulator holds length * 10 + 9 without wrapping.
  localparam int ACC_WIDTH = LEN_WIDTH + 4;
  localparam int CMP_WIDTH = (COUNT_WIDTH > SEL_WIDTH) ? COUNT_WIDTH : SEL_WIDTH;
  localparam int SAT_WIDTH = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

  localparam logic [COUNT_WIDTH-1:0]     COUNT_MAX     = '1;
  localparam logic [OUT_COUNT_WIDTH-1:0] OUT_COUNT_MAX = '1;

  localparam logic [BYTE_WIDTH-1:0] CHAR_DOT = 8'h2E;
  localparam logic [BYTE_WIDTH-1:0] CHAR_0   = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CHAR_9   = 8'h39;
  localparam logic [3:0]            DEC_BASE = 4'd10;

  typedef struct packed {
    logic                       is_selected;
    logic                       selected_end;
    logic                       frame_legal;
    logic [OUT_COUNT_WIDTH-1:0] element_count;
  } parse_result_t;

endpackage

@@ src/lpsd_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd channel interfaces
// Valid/ready channels for incoming frame bytes and for the marked results.
// ----------------------------------------------------------------------------
interface lpsd_in_if;
  logic                            valid;
  logic                            ready;
  logic [lpsd_pkg::BYTE_WIDTH-1:0] data_byte;
  logic                            frame_last;

  modport source(output valid, data_byte, frame_last, input ready);
  modport sink(input valid, data_byte, frame_last, output ready);
endinterface

interface lpsd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [lpsd_pkg::BYTE_WIDTH-1:0]      byte_out;
  logic                                 is_selected;
  logic                                 selected_end;
  logic                                 frame_end;
  logic                                 frame_legal;
  logic [lpsd_pkg::OUT_COUNT_WIDTH-1:0] element_count;

  modport source(output valid, byte_out, is_selected, selected_end, frame_end,
                 frame_legal, element_count, input ready);
  modport sink(input valid, byte_out, is_selected, selected_end, frame_end,
               frame_legal, element_count, output ready);
endinterface

@@ src/length_prefixed_string_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer
// Marks payload bytes of one chosen element in a length-prefixed frame and
// reports frame legality and element count on the last byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the output is not stalled and
// gives one result per byte. A byte accepted on the input lands in an input
// register. When the byte moves on, the parser updates its state and the
// result is loaded into the output register, from which it is offered.
// Throughput is one item per clock while the output is not stalled. While a
// finished result waits, the input takes at most one more byte into an empty
// input register and then holds ready low until the result is taken. Write
// selected_index only while no frame byte is in flight.

module length_prefixed_string_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lpsd_pkg::SEL_WIDTH-1:0]    cfg_wr_data,
  lpsd_in_if.sink                           in_ch,
  lpsd_out_if.source                        out_ch
);

  logic [lpsd_pkg::SEL_WIDTH-1:0]  selected_index;

  logic                            s1_valid;
  logic [lpsd_pkg::BYTE_WIDTH-1:0] s1_byte;
  logic                            s1_last;
  logic                            advance;

  logic                            out_valid;
  logic [lpsd_pkg::BYTE_WIDTH-1:0] out_byte;
  logic                            out_last;
  lpsd_pkg::parse_result_t         out_result;
  lpsd_pkg::parse_result_t         step_result;

  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_index <= '0;
    end else if (cfg_wr_en) begin
      selected_index <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.data_byte;
      s1_last <= in_ch.frame_last;
    end
  end

  lpsd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .data_byte      (s1_byte),
    .frame_last     (s1_last),
    .selected_index (selected_index),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= s1_byte;
      out_last   <= s1_last;
      out_result <= step_result;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.byte_out      = out_byte;
  assign out_ch.is_selected   = out_result.is_selected;
  assign out_ch.selected_end  = out_result.selected_end;
  assign out_ch.frame_end     = out_last;
  assign out_ch.frame_legal   = out_result.frame_legal;
  assign out_ch.element_count = out_result.element_count;

endmodule

@@ src/lpsd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_parser
// Parse state and the one-byte update of header length, payload countdown
// and element count.
// ----------------------------------------------------------------------------
module lpsd_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [lpsd_pkg::BYTE_WIDTH-1:0]     data_byte,
  input  logic                                frame_last,
  input  logic [lpsd_pkg::SEL_WIDTH-1:0]      selected_index,
  output lpsd_pkg::parse_result_t             result
);

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_PAYLOAD,
    MODE_ERROR
  } mode_t;

  mode_t                              parse_mode, parse_mode_next;
  logic [lpsd_pkg::LEN_WIDTH-1:0]     length_value, length_value_next;
  logic [lpsd_pkg::COUNT_WIDTH-1:0]   elements_done, elements_done_next;
  logic                               header_open, header_open_next;

  logic                               is_digit;
  logic [lpsd_pkg::ACC_WIDTH-1:0]     acc;
  logic [lpsd_pkg::BYTE_WIDTH-1:0]    digit_val;
  logic [lpsd_pkg::COUNT_WIDTH-1:0]   done_inc;
  logic [lpsd_pkg::LEN_WIDTH-1:0]     len_dec;
  logic                               sel_match;
  logic                               sel;
  logic                               sel_end;
  logic [lpsd_pkg::SAT_WIDTH-1:0]     cnt_ext;

  assign is_digit  = (data_byte >= lpsd_pkg::CHAR_0) && (data_byte <= lpsd_pkg::CHAR_9);
  assign digit_val = data_byte - lpsd_pkg::CHAR_0;
  assign acc = lpsd_pkg::ACC_WIDTH'(length_value) * lpsd_pkg::ACC_WIDTH'(lpsd_pkg::DEC_BASE)
             + lpsd_pkg::ACC_WIDTH'(digit_val[3:0]);
  assign done_inc = (elements_done != lpsd_pkg::COUNT_MAX) ?
                    elements_done + lpsd_pkg::COUNT_WIDTH'(1) : elements_done;
  assign len_dec = (length_value != '0) ?
                   length_value - lpsd_pkg::LEN_WIDTH'(1) : length_value;
  assign sel_match = lpsd_pkg::CMP_WIDTH'(elements_done) ==
                     lpsd_pkg::CMP_WIDTH'(selected_index);

  always_comb begin
    parse_mode_next    = parse_mode;
    length_value_next  = length_value;
    elements_done_next = elements_done;
    header_open_next   = header_open;
    sel                = 1'b0;
    sel_end            = 1'b0;
    case (parse_mode)
      MODE_HEADER: begin
        if (is_digit) begin
          // A length that no longer fits the counter ends parsing for the frame.
          if (acc[lpsd_pkg::ACC_WIDTH-1:lpsd_pkg::LEN_WIDTH] != '0) begin
            parse_mode_next = MODE_ERROR;
          end else begin
            length_value_next = acc[lpsd_pkg::LEN_WIDTH-1:0];
            header_open_next  = 1'b1;
          end
        end else if (data_byte == lpsd_pkg::CHAR_DOT) begin
          header_open_next = 1'b0;
          if (length_value == '0) begin
            elements_done_next = done_inc;
          end else begin
            parse_mode_next = MODE_PAYLOAD;
          end
        end else begin
          parse_mode_next = MODE_ERROR;
        end
      end
      MODE_PAYLOAD: begin
        sel               = sel_match;
        length_value_next = len_dec;
        if (len_dec == '0) begin
          sel_end            = sel_match;
          elements_done_next = done_inc;
          parse_mode_next    = MODE_HEADER;
        end
      end
      MODE_ERROR: begin
        parse_mode_next = MODE_ERROR;
      end
      default: begin
        parse_mode_next = MODE_ERROR;
      end
    endcase
  end

  assign cnt_ext = lpsd_pkg::SAT_WIDTH'(elements_done_next);

  always_comb begin
    result.is_selected  = sel;
    result.selected_end = sel_end;
    result.frame_legal  = frame_last && (parse_mode_next == MODE_HEADER) && !header_open_next;
    if (cnt_ext > lpsd_pkg::SAT_WIDTH'(lpsd_pkg::OUT_COUNT_MAX)) begin
      result.element_count = lpsd_pkg::OUT_COUNT_MAX;
    end else begin
      result.element_count = cnt_ext[lpsd_pkg::OUT_COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= MODE_HEADER;
      length_value  <= '0;
      elements_done <= '0;
      header_open   <= 1'b0;
    end else if (step) begin
      // All parse state starts over after the last byte of a frame.
      if (frame_last) begin
        parse_mode    <= MODE_HEADER;
        length_value  <= '0;
        elements_done <= '0;
        header_open   <= 1'b0;
      end else begin
        parse_mode    <= parse_mode_next;
        length_value  <= length_value_next;
        elements_done <= elements_done_next;
        header_open   <= header_open_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_mode == MODE_PAYLOAD |-> length_value != '0)
    else $error("payload mode with no bytes remaining");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    step && frame_last |=> parse_mode == MODE_HEADER && length_value == '0 &&
                           elements_done == '0 && !header_open)
    else $error("parse state not cleared after frame end");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    step && !frame_last && parse_mode == MODE_ERROR |=> parse_mode == MODE_ERROR)
    else $error("left error mode inside a frame");

  a_end_is_selected: assert property (@(posedge clk) disable iff (rst)
    result.selected_end |-> result.is_selected && parse_mode == MODE_PAYLOAD)
    else $error("selected end on an unselected byte");

  a_error_freezes_count: assert property (@(posedge clk) disable iff (rst)
    step && !frame_last && parse_mode == MODE_ERROR |=> $stable(elements_done))
    else $error("element count moved in error mode");
`endif

endmodule

@@ sim/length_prefixed_string_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer_tb
// Drives frames of length-prefixed elements one byte per item and checks
// every result against a cycle-free predictor of the parser. A short table
// of hand-picked frames comes first, then random frames (mostly well formed,
// some damaged, some noise) under several selected_index settings, with
// random gaps on both channels and one long hold-off on the result side.
// The run ends with an element that carries the largest legal length and is
// cut short by the frame end.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer_tb;
  import lpsd_pkg::*;

  localparam int PHASE_ITEMS   = 130;
  localparam int PRESSURE_HOLD = 300;
  localparam int MAX_REPORTS   = 100;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {MODE_HEADER, MODE_PAYLOAD, MODE_ERROR} parse_mode_t;
  typedef enum int {DAMAGE_CUT, DAMAGE_BAD_BYTE, DAMAGE_TOO_LONG, DAMAGE_OPEN_HEADER} damage_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0]      data;
    logic                       is_selected;
    logic                       selected_end;
    logic                       frame_end;
    logic                       frame_legal;
    logic [OUT_COUNT_WIDTH-1:0] element_count;
  } byte_mark_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0]      data;
    logic                       last;
    logic                       typed;
    logic                       sel;
    logic                       sel_end;
    logic                       legal;
    logic [OUT_COUNT_WIDTH-1:0] count;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [SEL_WIDTH-1:0] cfg_wr_data;

  lpsd_in_if  in_ch();
  lpsd_out_if out_ch();

  length_prefixed_string_deframer uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predictor state
  parse_mode_t            mode;
  logic [LEN_WIDTH-1:0]   len_left;
  logic [COUNT_WIDTH-1:0] done_count;
  logic                   header_seen;
  logic [SEL_WIDTH-1:0]   chosen_index;

  byte_mark_t expected_marks[$];
  stim_row_t  directed_rows[$];
  int         error_count;
  int         items_sent;
  bit         idling_on;
  bit         hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_parse();
    mode        = MODE_HEADER;
    len_left    = '0;
    done_count  = '0;
    header_seen = 1'b0;
  endfunction

  function automatic void bump_count();
    if (done_count != COUNT_MAX) done_count++;
  endfunction

  function automatic byte_mark_t mark_byte(input logic [7:0] b, input logic last);
    byte_mark_t             r;
    logic [ACC_WIDTH-1:0]   acc;
    r           = '0;
    r.data      = b;
    r.frame_end = last;
    case (mode)
      MODE_HEADER: begin
        if (b >= CHAR_0 && b <= CHAR_9) begin
          acc = ACC_WIDTH'(len_left) * ACC_WIDTH'(DEC_BASE) + ACC_WIDTH'(b - CHAR_0);
          if (acc > ACC_WIDTH'(LEN_MAX)) begin
            mode = MODE_ERROR;
          end else begin
            len_left    = acc[LEN_WIDTH-1:0];
            header_seen = 1'b1;
          end
        end else if (b == CHAR_DOT) begin
          header_seen = 1'b0;
          if (len_left == '0) bump_count();
          else mode = MODE_PAYLOAD;
        end else begin
          mode = MODE_ERROR;
        end
      end
      MODE_PAYLOAD: begin
        r.is_selected = (done_count == chosen_index);
        if (len_left != '0) len_left--;
        if (len_left == '0) begin
          r.selected_end = r.is_selected;
          bump_count();
          mode = MODE_HEADER;
        end
      end
      default: ;
    endcase
    if (last) r.frame_legal = (mode == MODE_HEADER) && !header_seen;
    r.element_count = (done_count > OUT_COUNT_MAX) ? OUT_COUNT_MAX
                                                   : OUT_COUNT_WIDTH'(done_count);
    if (last) clear_parse();
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic l,
                                  input logic t = 1'b0, input logic s = 1'b0,
                                  input logic e = 1'b0, input logic g = 1'b0,
                                  input logic [OUT_COUNT_WIDTH-1:0] c = '0);
    stim_row_t row;
    row = '{data: d, last: l, typed: t, sel: s, sel_end: e, legal: g, count: c};
    directed_rows.push_back(row);
  endfunction

  // The expectation is taken at acceptance; a typed one replaces the
  // prediction, but the predictor still steps so its state stays in line.
  task automatic send_item(input logic [7:0] b, input logic last,
                           input bit use_given, input byte_mark_t given);
    int         gap;
    byte_mark_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    predicted = mark_byte(b, last);
    expected_marks.push_back(use_given ? given : predicted);
    items_sent++;
  endtask

  task automatic write_index(input logic [SEL_WIDTH-1:0] v);
    in_ch.valid <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    chosen_index = v;
  endtask

  task automatic send_random_frame();
    logic [7:0] frame_q[$];
    logic [7:0] bad;
    string      digits;
    int         kind;
    int         len;
    int         pick;
    damage_t    damage;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Noise leaning on header characters so short runs of digits turn up.
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) frame_q.push_back(8'($urandom_range(0, 255)));
        else if (pick == 1) frame_q.push_back(CHAR_DOT);
        else frame_q.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) len = 0;
        else if (pick < 92) len = $urandom_range(1, 6);
        else len = $urandom_range(7, 40);
        if ($urandom_range(0, 4) == 0) frame_q.push_back(CHAR_0);
        if (len != 0 || $urandom_range(0, 1) == 0) begin
          digits = $sformatf("%0d", len);
          for (int k = 0; k < digits.len(); k++) frame_q.push_back(digits[k]);
        end
        frame_q.push_back(CHAR_DOT);
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 28) begin
        damage = damage_t'($urandom_range(0, 3));
        case (damage)
          DAMAGE_CUT: begin
            if (frame_q.size() > 1)
              repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
          end
          DAMAGE_BAD_BYTE: begin
            do bad = 8'($urandom_range(0, 255));
            while ((bad >= CHAR_0 && bad <= CHAR_9) || bad == CHAR_DOT);
            frame_q.push_back(bad);
            repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
          end
          DAMAGE_TOO_LONG: begin
            digits = $sformatf("%0d", $urandom_range(int'(LEN_MAX) + 1, 999999));
            for (int k = 0; k < digits.len(); k++) frame_q.push_back(digits[k]);
            frame_q.push_back(CHAR_DOT);
            repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            digits = $sformatf("%0d", $urandom_range(1, 9999));
            for (int k = 0; k < digits.len(); k++) frame_q.push_back(digits[k]);
          end
        endcase
      end
    end
    for (int k = 0; k < frame_q.size(); k++)
      send_item(frame_q[k], k == frame_q.size() - 1, 1'b0, '0);
  endtask

  task automatic run_random_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) send_random_frame();
  endtask

  initial begin : result_sink
    int         stall_left;
    int         hold_left;
    byte_mark_t want;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_marks.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("result with no expectation waiting, byte_out %0h", out_ch.byte_out);
        end else begin
          want = expected_marks.pop_front();
          check_field("byte_out", 32'(want.data), 32'(out_ch.byte_out));
          check_field("is_selected", 32'(want.is_selected), 32'(out_ch.is_selected));
          check_field("selected_end", 32'(want.selected_end), 32'(out_ch.selected_end));
          check_field("frame_end", 32'(want.frame_end), 32'(out_ch.frame_end));
          check_field("frame_legal", 32'(want.frame_legal), 32'(out_ch.frame_legal));
          check_field("element_count", 32'(want.element_count),
                      32'(out_ch.element_count));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = PRESSURE_HOLD;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        stall_left   = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                    : $urandom_range(7, 39);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    byte_mark_t given;
    string      digits;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.frame_last = 1'b0;
    error_count      = 0;
    items_sent       = 0;
    idling_on        = 1'b1;
    hold_request     = 1'b0;
    chosen_index     = '0;
    clear_parse();

    // Empty element alone, then "0." as an explicit zero length.
    add_row(CHAR_DOT, 1, 1, 0, 0, 1, 1);
    add_row("0", 0);
    add_row(CHAR_DOT, 1, 1, 0, 0, 1, 1);
    // "2.ab": both payload bytes of element zero are marked.
    add_row("2", 0);
    add_row(CHAR_DOT, 0);
    add_row("a", 0);
    add_row("b", 1, 1, 1, 1, 1, 1);
    // Two one-byte elements; only the first is selected.
    add_row("1", 0);
    add_row(CHAR_DOT, 0);
    add_row("x", 0);
    add_row("1", 0);
    add_row(CHAR_DOT, 0);
    add_row(8'hFF, 1, 1, 0, 0, 1, 2);
    // Bad header bytes at both ends of the byte range and next to the digits.
    add_row(8'hFF, 1, 1, 0, 0, 0, 0);
    add_row(8'h00, 1, 1, 0, 0, 0, 0);
    add_row(":", 1, 1, 0, 0, 0, 0);
    // Frame ends inside a header.
    add_row("5", 1, 1, 0, 0, 0, 0);
    // Frame ends inside a payload: the byte stays marked, nothing is counted.
    add_row("3", 0);
    add_row(CHAR_DOT, 0);
    add_row("a", 1, 1, 1, 0, 0, 0);
    // One past the largest length.
    add_row("6", 0);
    add_row("5", 0);
    add_row("5", 0);
    add_row("3", 0);
    add_row("6", 1, 1, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_index('0);
    foreach (directed_rows[i]) begin
      row                 = directed_rows[i];
      given.data          = row.data;
      given.is_selected   = row.sel;
      given.selected_end  = row.sel_end;
      given.frame_end     = row.last;
      given.frame_legal   = row.legal;
      given.element_count = row.count;
      send_item(row.data, row.last, row.typed, given);
    end

    write_index(SEL_WIDTH'(1));
    run_random_phase(PHASE_ITEMS);
    write_index('0);
    // The result side stops for a long while so the input backs up.
    hold_request = 1'b1;
    run_random_phase(PHASE_ITEMS);
    write_index(SEL_WIDTH'(2));
    idling_on = 1'b0;
    run_random_phase(PHASE_ITEMS);
    idling_on = 1'b1;
    write_index('1);
    run_random_phase(PHASE_ITEMS);
    write_index(SEL_WIDTH'(3));
    run_random_phase(PHASE_ITEMS);
    write_index(SEL_WIDTH'($urandom_range(0, 4)));
    run_random_phase(PHASE_ITEMS);
    write_index(SEL_WIDTH'($urandom));
    run_random_phase(100);

    // The largest legal length is taken as a header; the frame then ends a
    // few payload bytes in, so those bytes are marked and the frame is illegal.
    idling_on = 1'b0;
    write_index('0);
    digits = $sformatf("%0d", LEN_MAX);
    for (int k = 0; k < digits.len(); k++) send_item(digits[k], 1'b0, 1'b0, '0);
    send_item(CHAR_DOT, 1'b0, 1'b0, '0);
    for (int k = 0; k < 4; k++)
      send_item(8'($urandom_range(0, 255)), k == 3, 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
